// ----- hw/rtl/cod_pkg.sv -----
package cod_pkg;

	localparam int XY_W = 32;
	localparam int Z_W = 34;
	localparam int ATAN_N = 24;
	localparam int LIMIT_W = 15;
	localparam int FIELD_W = 16;
	localparam int PHASE_W = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16366;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

	// Arctangent of 2^-i in units of 2^32 per turn.
	localparam logic [PHASE_W-1:0] ATAN_PHASE [ATAN_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef logic signed [XY_W-1:0] cod_xy_t;
	typedef logic signed [Z_W-1:0] cod_z_t;

	typedef struct packed {
		cod_xy_t x;
		cod_xy_t y;
		cod_z_t z;
		logic flip;
	} cod_lane_t;

	typedef struct packed {
		cod_lane_t pitch;
		cod_lane_t yaw;
		logic [FIELD_W-1:0] cur_pitch;
		logic [FIELD_W-1:0] cur_yaw;
	} cod_stage_t;

	typedef struct packed {
		logic [FIELD_W-1:0] cur_yaw;
		logic [FIELD_W-1:0] cur_pitch;
		logic [FIELD_W-1:0] dir_z;
		logic [FIELD_W-1:0] dir_y;
		logic [FIELD_W-1:0] dir_x;
	} cod_result_t;

	// Phases in the left half of the circle are turned by half a turn and
	// the results negated at the end.
	function automatic cod_lane_t lane_init(input logic [PHASE_W-1:0] phase);
		cod_lane_t l;
		logic flip;
		logic [PHASE_W-1:0] p;
		flip = phase[PHASE_W-1] ^ phase[PHASE_W-2];
		p = {phase[PHASE_W-1] ^ flip, phase[PHASE_W-2:0]};
		l.x = CORDIC_GAIN;
		l.y = '0;
		l.z = Z_W'($signed(p));
		l.flip = flip;
		return l;
	endfunction

endpackage

// ----- hw/rtl/camera_orientation_direction.sv -----
// Channel      Direction  Width  Contents
// s_axis       in         32     pitch_delta, yaw_delta
// m_axis       out        80     dir_x, dir_y, dir_z, cur_pitch, cur_yaw
// pitch_limit  in         15     write enable and data, no read-back
//
// The pipeline has one angle update stage, one CORDIC cell per step (at most 24),
// two product and rounding stages and the output register.
// One transaction is accepted per cycle while the output side keeps up.
// Reset clears the angles to zero and the pitch limit to 16366.
// When the output stalls, one result is caught in a skid register and the whole
// pipeline then holds until it drains.
module camera_orientation_direction #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata, // pitch_delta, yaw_delta
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [79:0] m_axis_tdata, // dir_x, dir_y, dir_z, cur_pitch, cur_yaw
	input  logic pitch_limit_we,
	input  logic [14:0] pitch_limit_wdata
);

	localparam int NSTEP = (CORDIC_STEPS < cod_pkg::ATAN_N) ? CORDIC_STEPS : cod_pkg::ATAN_N;

	logic en;
	logic in_accept;
	logic [NSTEP:0] chain_valid;
	cod_pkg::cod_stage_t chain_data [NSTEP+1];
	logic pipe_valid;
	cod_pkg::cod_result_t pipe_result;

	logic out_valid_q;
	cod_pkg::cod_result_t out_data_q;
	logic skid_valid_q;
	cod_pkg::cod_result_t skid_data_q;

	assign en = !skid_valid_q;
	assign s_axis_tready = en;
	assign in_accept = s_axis_tvalid && en;

	cod_angle_acc #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_accept),
		.pitch_delta($signed(s_axis_tdata[15:0])),
		.yaw_delta($signed(s_axis_tdata[31:16])),
		.limit_we(pitch_limit_we),
		.limit_wdata(pitch_limit_wdata),
		.valid_s1(chain_valid[0]),
		.data_s1(chain_data[0])
	);

	for (genvar g = 0; g < NSTEP; g++) begin : g_cell
		cod_cordic_cell #(
			.STEP(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(chain_valid[g]),
			.in_data(chain_data[g]),
			.valid_s1(chain_valid[g+1]),
			.data_s1(chain_data[g+1])
		);
	end

	cod_product u_product (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(chain_valid[NSTEP]),
		.in_data(chain_data[NSTEP]),
		.valid_s2(pipe_valid),
		.result_s2(pipe_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= pipe_valid;
		end else if (pipe_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_axis_tready) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_valid_q || m_axis_tready) begin
			if (pipe_valid) begin
				out_data_q <= pipe_result;
			end
		end else if (pipe_valid) begin
			skid_data_q <= pipe_result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

// ----- hw/rtl/cod_angle_acc.sv -----
module cod_angle_acc #(
	parameter int ANGLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [15:0] pitch_delta,
	input  logic signed [15:0] yaw_delta,
	input  logic limit_we,
	input  logic [cod_pkg::LIMIT_W-1:0] limit_wdata,
	output logic valid_s1,
	output cod_pkg::cod_stage_t data_s1
);

	localparam int SUM_W = (ANGLE_BITS > 16 ? ANGLE_BITS : 16) + 1;
	localparam logic signed [SUM_W-1:0] QUARTER = SUM_W'(64'd1 << (ANGLE_BITS - 2));

	logic signed [ANGLE_BITS-1:0] pitch_q;
	logic [ANGLE_BITS-1:0] yaw_q;
	logic [cod_pkg::LIMIT_W-1:0] limit_q;

	logic signed [SUM_W-1:0] lim_ext;
	logic signed [SUM_W-1:0] lim_eff;
	logic signed [SUM_W-1:0] pitch_sum;
	logic signed [SUM_W-1:0] pitch_next;
	logic [SUM_W-1:0] yaw_sum;
	logic [SUM_W-1:0] yaw_wide;
	logic signed [ANGLE_BITS-1:0] pitch_new;
	logic [ANGLE_BITS-1:0] yaw_new;
	cod_pkg::cod_stage_t stage_next;

	always_comb begin
		lim_ext = $signed(SUM_W'(limit_q));
		lim_eff = (lim_ext > QUARTER) ? QUARTER : lim_ext;
		pitch_sum = SUM_W'(pitch_q) + SUM_W'(pitch_delta);
		if (pitch_sum < -lim_eff) begin
			pitch_next = -lim_eff;
		end else if (pitch_sum > lim_eff) begin
			pitch_next = lim_eff;
		end else begin
			pitch_next = pitch_sum;
		end
		pitch_new = pitch_next[ANGLE_BITS-1:0];
		yaw_sum = SUM_W'(yaw_q) + SUM_W'(yaw_delta);
		yaw_new = yaw_sum[ANGLE_BITS-1:0];
		yaw_wide = SUM_W'(yaw_new);

		stage_next.pitch = cod_pkg::lane_init({pitch_new,
			{(cod_pkg::PHASE_W - ANGLE_BITS){1'b0}}});
		stage_next.yaw = cod_pkg::lane_init({yaw_new,
			{(cod_pkg::PHASE_W - ANGLE_BITS){1'b0}}});
		stage_next.cur_pitch = pitch_next[15:0];
		stage_next.cur_yaw = yaw_wide[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			yaw_q <= '0;
			limit_q <= cod_pkg::LIMIT_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (limit_we) begin
				limit_q <= limit_wdata;
			end
			if (in_valid) begin
				pitch_q <= pitch_new;
				yaw_q <= yaw_new;
			end
			if (en) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1 <= stage_next;
		end
	end

endmodule

// ----- hw/rtl/cod_cordic_cell.sv -----
module cod_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  cod_pkg::cod_stage_t in_data,
	output logic valid_s1,
	output cod_pkg::cod_stage_t data_s1
);

	localparam cod_pkg::cod_z_t ATAN_STEP =
		$signed(cod_pkg::Z_W'(cod_pkg::ATAN_PHASE[STEP]));

	function automatic cod_pkg::cod_lane_t rotate(input cod_pkg::cod_lane_t l);
		cod_pkg::cod_lane_t r;
		cod_pkg::cod_xy_t dx;
		cod_pkg::cod_xy_t dy;
		dx = l.y >>> STEP;
		dy = l.x >>> STEP;
		r.flip = l.flip;
		if (!l.z[cod_pkg::Z_W-1]) begin
			r.x = l.x - dx;
			r.y = l.y + dy;
			r.z = l.z - ATAN_STEP;
		end else begin
			r.x = l.x + dx;
			r.y = l.y - dy;
			r.z = l.z + ATAN_STEP;
		end
		return r;
	endfunction

	cod_pkg::cod_stage_t stage_next;

	always_comb begin
		stage_next = in_data;
		stage_next.pitch = rotate(in_data.pitch);
		stage_next.yaw = rotate(in_data.yaw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1 <= stage_next;
		end
	end

endmodule

// ----- hw/rtl/cod_product.sv -----
module cod_product (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  cod_pkg::cod_stage_t in_data,
	output logic valid_s2,
	output cod_pkg::cod_result_t result_s2
);

	function automatic logic [15:0] sat16(input logic signed [63:0] v);
		logic [15:0] r;
		if (v > 64'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -64'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	cod_pkg::cod_xy_t cos_p;
	cod_pkg::cod_xy_t sin_p;
	cod_pkg::cod_xy_t cos_y;
	cod_pkg::cod_xy_t sin_y;

	logic valid_s1;
	logic signed [63:0] prod_x_s1;
	logic signed [63:0] prod_z_s1;
	cod_pkg::cod_xy_t sin_p_s1;
	logic [15:0] cur_pitch_s1;
	logic [15:0] cur_yaw_s1;

	logic signed [63:0] round_x;
	logic signed [63:0] round_y;
	logic signed [63:0] round_z;
	cod_pkg::cod_result_t result_next;

	always_comb begin
		cos_p = in_data.pitch.flip ? -in_data.pitch.x : in_data.pitch.x;
		sin_p = in_data.pitch.flip ? -in_data.pitch.y : in_data.pitch.y;
		cos_y = in_data.yaw.flip ? -in_data.yaw.x : in_data.yaw.x;
		sin_y = in_data.yaw.flip ? -in_data.yaw.y : in_data.yaw.y;
	end

	// Products are Q60 and the pitch sine is Q30; both round half up to Q1.15.
	always_comb begin
		round_x = (prod_x_s1 + (64'sd1 <<< 44)) >>> 45;
		round_z = (prod_z_s1 + (64'sd1 <<< 44)) >>> 45;
		round_y = (64'(sin_p_s1) + (64'sd1 <<< 14)) >>> 15;
		result_next.dir_x = sat16(round_x);
		result_next.dir_y = sat16(round_y);
		result_next.dir_z = sat16(round_z);
		result_next.cur_pitch = cur_pitch_s1;
		result_next.cur_yaw = cur_yaw_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			prod_x_s1 <= 64'(cos_y) * 64'(cos_p);
			prod_z_s1 <= 64'(sin_y) * 64'(cos_p);
			sin_p_s1 <= sin_p;
			cur_pitch_s1 <= in_data.cur_pitch;
			cur_yaw_s1 <= in_data.cur_yaw;
		end
		if (en && valid_s1) begin
			result_s2 <= result_next;
		end
	end

endmodule

// ----- hw/rtl/cod_checker.sv -----
module cod_checker #(
	parameter int ANGLE_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic pitch_limit_we,
	input logic [14:0] pitch_limit_wdata
);

	localparam logic signed [16:0] QUARTER = 17'(64'd1 << (ANGLE_BITS - 2));

	logic [14:0] limit_q;
	logic [7:0] inflight_q;
	logic in_acc;
	logic out_acc;
	logic signed [16:0] lim_ext;
	logic signed [16:0] lim_eff;
	logic signed [16:0] cur_pitch;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign lim_ext = $signed(17'(limit_q));
	assign lim_eff = (lim_ext > QUARTER) ? QUARTER : lim_ext;
	assign cur_pitch = 17'($signed(m_axis_tdata[63:48]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= cod_pkg::LIMIT_RESET;
			inflight_q <= '0;
		end else begin
			if (pitch_limit_we) begin
				limit_q <= pitch_limit_wdata;
			end
			inflight_q <= inflight_q + 8'(in_acc) - 8'(out_acc);
		end
	end

	// A result that waits keeps its value until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction changed while stalled");

	// Input is only refused when a result is waiting at the output.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input refused with no result pending");

	// Every result stems from an accepted input transaction.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> inflight_q != 8'd0)
		else $error("result without a matching input transaction");

	// The reported pitch stays within the configured limit.
	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (ANGLE_BITS <= 16) |-> (cur_pitch <= lim_eff) && (cur_pitch >= -lim_eff))
		else $error("pitch outside the configured limit");

endmodule

bind camera_orientation_direction cod_checker #(.ANGLE_BITS(ANGLE_BITS)) u_cod_checker (.*);

// ----- bench/camera_orientation_direction_test.sv -----
`timescale 1ns / 1ps

module camera_orientation_direction_test;

	localparam int ANGLE_BITS = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int LATENCY = CORDIC_STEPS + 4;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_MAX = 10;
	localparam longint QUARTER_TURN = 64'sd1 <<< (ANGLE_BITS - 2);
	localparam longint TURN_MASK = (64'sd1 <<< ANGLE_BITS) - 1;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint ARCTAN_STEP [16] = '{
		64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
		64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
		64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
		64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic pitch_limit_we = 1'b0;
	logic [14:0] pitch_limit_wdata = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_serial = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	longint limit_copy;
	longint pitch_now;
	longint yaw_now;
	cod_pkg::cod_result_t expected_views [$];

	camera_orientation_direction #(
		.ANGLE_BITS(ANGLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.pitch_limit_we(pitch_limit_we),
		.pitch_limit_wdata(pitch_limit_wdata)
	);

	always #4 clk = ~clk;

	// Cosine and sine in Q2.30 of an angle given in units of 2^ANGLE_BITS per turn.
	function automatic void sin_cos_q30(input longint angle, output longint c,
			output longint s);
		logic [31:0] phase;
		logic flip;
		longint x, y, z, dx, dy;
		phase = 32'(angle <<< (32 - ANGLE_BITS));
		flip = phase[31] ^ phase[30];
		if (flip) begin
			phase[31] = ~phase[31];
		end
		z = longint'($signed(phase));
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN_STEP[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN_STEP[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic [15:0] round_q15(input longint v, input int frac);
		longint r;
		r = (v + (64'sd1 <<< (frac - 16))) >>> (frac - 15);
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		return 16'(r);
	endfunction

	function automatic cod_pkg::cod_result_t predict_view(input logic signed [15:0] pitch_delta,
			input logic signed [15:0] yaw_delta);
		cod_pkg::cod_result_t v;
		longint lim, p, cp, sp, cy, sy;
		lim = (limit_copy > QUARTER_TURN) ? QUARTER_TURN : limit_copy;
		p = pitch_now + longint'(pitch_delta);
		if (p < -lim) begin
			p = -lim;
		end
		if (p > lim) begin
			p = lim;
		end
		pitch_now = p;
		yaw_now = (yaw_now + longint'(yaw_delta)) & TURN_MASK;
		sin_cos_q30(pitch_now, cp, sp);
		sin_cos_q30(yaw_now, cy, sy);
		v.dir_x = round_q15(cy * cp, 60);
		v.dir_y = round_q15(sp, 30);
		v.dir_z = round_q15(sy * cp, 60);
		v.cur_pitch = 16'(pitch_now);
		v.cur_yaw = 16'(yaw_now);
		return v;
	endfunction

	// Follows every accepted input transaction and every limit write.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_copy = longint'(cod_pkg::LIMIT_RESET);
			pitch_now = 0;
			yaw_now = 0;
		end else begin
			if (pitch_limit_we) begin
				limit_copy = longint'(pitch_limit_wdata);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_views.push_back(predict_view($signed(s_axis_tdata[15:0]),
					$signed(s_axis_tdata[31:16])));
			end
		end
	end

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$display("%0t: %s expected %0d (0x%04h), got %0d (0x%04h)", $realtime,
					field, $signed(want), want, $signed(got), got);
			end
		end
	endtask

	always @(posedge clk) begin
		cod_pkg::cod_result_t got;
		cod_pkg::cod_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_views.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: unexpected result transaction 0x%020h", $realtime,
						m_axis_tdata);
				end
			end else begin
				want = expected_views.pop_front();
				compare_field("dir_x", want.dir_x, got.dir_x);
				compare_field("dir_y", want.dir_y, got.dir_y);
				compare_field("dir_z", want.dir_z, got.dir_z);
				compare_field("cur_pitch", want.cur_pitch, got.cur_pitch);
				compare_field("cur_yaw", want.cur_yaw, got.cur_yaw);
			end
		end
	end

	// The receiver stalls at random, and for a long stretch when one is requested.
	always @(posedge clk) begin
		if (hold_serial != hold_seen) begin
			hold_seen <= hold_serial;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_angles(input logic [15:0] pitch_delta, input logic [15:0] yaw_delta);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {yaw_delta, pitch_delta};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_views.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_pitch_limit(input logic [14:0] value);
		pitch_limit_we <= 1'b1;
		pitch_limit_wdata <= value;
		@(posedge clk);
		pitch_limit_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_stall_pct <= receiver_pct;
		@(posedge clk);
	endtask

	// Mostly small turns, with full-range
	// deltas, hard pushes into the clamp and still frames mixed in.
	task automatic send_random_angles(input int count);
		logic [15:0] pd, yd;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					pd = 16'($signed($urandom_range(4095)) - 2048);
					yd = 16'($signed($urandom_range(8191)) - 4096);
				end
				6, 7: begin
					pd = 16'($urandom);
					yd = 16'($urandom);
				end
				8: begin
					pd = $urandom_range(1) ? 16'($urandom_range(32767, 12000))
						: 16'(-$signed($urandom_range(32768, 12000)));
					yd = 16'($urandom_range(255));
				end
				default: begin
					pd = '0;
					yd = '0;
				end
			endcase
			send_angles(pd, yd);
		end
	endtask

	task automatic test_reset_limit_extremes();
		set_idling(0, 0);
		send_angles(16'd0, 16'd0);
		send_angles(16'd16384, 16'd16384);
		send_angles(16'h7FFF, 16'h7FFF);
		send_angles(16'h8000, 16'h8000);
		send_angles(16'h8000, 16'h8000);
		send_angles(16'hFFFF, 16'hFFFF);
		send_angles(16'd1, 16'd1);
		send_angles(16'd16366, 16'd8192);
		send_angles(16'd1, 16'd24576);
		send_angles(16'hC012, 16'hE000);
		send_angles(16'hFFFF, 16'hAAAA);
		send_angles(16'h5555, 16'h5555);
		send_angles(16'h8000, 16'd32768);
		send_angles(16'd8192, 16'd1);
		send_angles(16'd0, 16'hFFFF);
		drain_pipeline();
	endtask

	// A zero limit pins the pitch, a quarter turn reaches straight up and down,
	// and a limit above a quarter turn behaves as a quarter turn.
	task automatic test_limit_settings();
		logic [14:0] limits [5];
		limits = '{15'd0, 15'd16384, 15'h7FFF, 15'd1, 15'($urandom_range(16383))};
		foreach (limits[k]) begin
			write_pitch_limit(limits[k]);
			send_angles(16'h7FFF, 16'd0);
			send_angles(16'h7FFF, 16'd16384);
			send_angles(16'h8000, 16'd16384);
			send_angles(16'h8000, 16'd32768);
			send_angles(16'd1, 16'hC000);
			send_angles(16'hFFFF, 16'hFFFF);
			send_random_angles(30);
			drain_pipeline();
		end
		write_pitch_limit(cod_pkg::LIMIT_RESET);
	endtask

	task automatic test_random_traffic();
		set_idling(11, 59);
		send_random_angles(320);
		drain_pipeline();
		write_pitch_limit(15'($urandom_range(16384, 4000)));
		set_idling(59, 11);
		send_random_angles(320);
		drain_pipeline();
		write_pitch_limit(cod_pkg::LIMIT_RESET);
		set_idling(0, 0);
		send_random_angles(320);
		drain_pipeline();
	endtask

	task automatic test_output_backpressure();
		set_idling(0, 0);
		hold_serial <= hold_serial + 1;
		send_random_angles(80);
		drain_pipeline();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_limit_extremes();
		test_limit_settings();
		test_random_traffic();
		test_output_backpressure();
		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0 && expected_views.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
